[design/tnsit_pkg.sv]
// shared types and constants for the sorted top-n table
`default_nettype none

package tnsit_pkg;

  localparam int KEY_W     = 16;
  localparam int DEPTH_W   = 8;
  localparam int IO_PAY_W  = 32;
  localparam int IDX_W     = 3;
  localparam int COUNT_W   = 4;
  localparam int GAMES_W   = 16;
  localparam int MODE_W    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic capture;
    logic walk_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_last;
  } dp_status_t;

endpackage

`default_nettype wire

[design/tnsit_dp.sv]
// datapath: slot memory, insert walk, counters and result register
`default_nettype none

module tnsit_dp #(
  parameter int TABLE_SLOTS  = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire tnsit_pkg::dp_cmd_t                   cmd,
  output tnsit_pkg::dp_status_t                     status,
  input  wire logic [tnsit_pkg::MODE_W-1:0]         mode,
  input  wire logic [tnsit_pkg::KEY_W-1:0]          new_key,
  input  wire logic [tnsit_pkg::DEPTH_W-1:0]        new_depth,
  input  wire logic [tnsit_pkg::IO_PAY_W-1:0]       new_payload,
  input  wire logic [tnsit_pkg::IDX_W-1:0]          read_index,
  output logic                                      inserted,
  output logic [tnsit_pkg::IDX_W-1:0]               insert_slot,
  output logic [tnsit_pkg::KEY_W-1:0]               entry_key,
  output logic [tnsit_pkg::DEPTH_W-1:0]             entry_depth,
  output logic [tnsit_pkg::IO_PAY_W-1:0]            entry_payload,
  output logic [tnsit_pkg::COUNT_W-1:0]             filled_count,
  output logic [tnsit_pkg::GAMES_W-1:0]             games_total
);

  localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int PW = PAYLOAD_BITS;
  localparam int EW = tnsit_pkg::KEY_W + tnsit_pkg::DEPTH_W + PW;

  // captured item
  tnsit_pkg::mode_t                 mode_q;
  logic [tnsit_pkg::KEY_W-1:0]      key_q;
  logic [tnsit_pkg::DEPTH_W-1:0]    depth_q;
  logic [PW-1:0]                    pay_q;
  logic                             idx_ok_q;

  // slot memory, word is {key, depth, payload}
  logic [EW-1:0]                    entry_mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0]           slot_vld;
  logic [EW-1:0]                    rd_data;
  logic                             rd_vld;

  // walk state
  logic [AW-1:0]                    walk_idx;
  logic                             found;
  logic [AW-1:0]                    ins_pos;
  logic [EW-1:0]                    carry;
  logic [CW-1:0]                    count;
  logic [tnsit_pkg::GAMES_W-1:0]    games;

  tnsit_pkg::mode_t                 in_mode;
  logic [AW+2:0]                    ridx_ext;
  logic [AW-1:0]                    ridx;
  logic [PW+31:0]                   pay_in_ext;
  logic [EW-1:0]                    eff_word;
  logic [tnsit_pkg::KEY_W-1:0]      eff_key;
  logic [tnsit_pkg::DEPTH_W-1:0]    eff_depth;
  logic [PW+31:0]                   eff_pay_ext;
  logic [AW+2:0]                    pos_ext;
  logic [CW+3:0]                    count_ext;
  logic                             walk_last;
  logic                             take;
  logic                             shift;
  logic                             mem_we;
  logic [EW-1:0]                    wr_data;
  logic                             rd_en;
  logic [AW-1:0]                    rd_addr;

  assign in_mode    = tnsit_pkg::mode_t'(mode);
  assign ridx_ext   = (AW+3)'(read_index);
  assign ridx       = ridx_ext[AW-1:0];
  assign pay_in_ext = (PW+32)'(new_payload);

  // slots never written since reset read as zero
  assign eff_word    = rd_vld ? rd_data : '0;
  assign eff_key     = eff_word[EW-1 -: tnsit_pkg::KEY_W];
  assign eff_depth   = eff_word[PW +: tnsit_pkg::DEPTH_W];
  assign eff_pay_ext = (PW+32)'(eff_word[PW-1:0]);

  assign walk_last        = (walk_idx == AW'(TABLE_SLOTS - 1));
  assign status.walk_last = walk_last;

  // first empty slot or smaller key takes the new entry, later slots take the carry
  assign take    = cmd.walk_step && !found
                   && ((eff_depth == '0) || (key_q > eff_key));
  assign shift   = cmd.walk_step && found;
  assign mem_we  = take || shift;
  assign wr_data = take ? {key_q, depth_q, pay_q} : carry;

  assign rd_en   = cmd.capture || (cmd.walk_step && !walk_last);
  always_comb begin
    if (cmd.capture) begin
      rd_addr = (in_mode == tnsit_pkg::MODE_INSERT) ? '0 : ridx;
    end else begin
      rd_addr = walk_idx + AW'(1);
    end
  end

  assign pos_ext   = (AW+3)'(ins_pos);
  assign count_ext = (CW+4)'(count);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[walk_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
      rd_vld   <= 1'b0;
      walk_idx <= '0;
      found    <= 1'b0;
      count    <= '0;
      games    <= '0;
    end else begin
      if (mem_we) begin
        slot_vld[walk_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= slot_vld[rd_addr];
      end
      if (cmd.capture) begin
        walk_idx <= '0;
        found    <= 1'b0;
        if (in_mode == tnsit_pkg::MODE_TICK) begin
          games <= games + tnsit_pkg::GAMES_W'(1);
        end
      end else if (cmd.walk_step) begin
        if (!walk_last) begin
          walk_idx <= walk_idx + AW'(1);
        end
        if (take) begin
          found <= 1'b1;
        end
        // the old last entry falls off the end
        if (walk_last && mem_we) begin
          count <= count + CW'(depth_q != '0) - CW'(eff_depth != '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= in_mode;
      key_q    <= new_key;
      depth_q  <= new_depth;
      pay_q    <= pay_in_ext[PW-1:0];
      idx_ok_q <= ({{(32-tnsit_pkg::IDX_W){1'b0}}, read_index} < TABLE_SLOTS);
    end
    if (mem_we) begin
      carry <= eff_word;
    end
    if (take) begin
      ins_pos <= walk_idx;
    end
    if (cmd.load_out) begin
      inserted     <= (mode_q == tnsit_pkg::MODE_INSERT) && found;
      insert_slot  <= ((mode_q == tnsit_pkg::MODE_INSERT) && found) ? pos_ext[2:0] : '0;
      if ((mode_q == tnsit_pkg::MODE_READ) && idx_ok_q) begin
        entry_key     <= eff_key;
        entry_depth   <= eff_depth;
        entry_payload <= eff_pay_ext[31:0];
      end else begin
        entry_key     <= '0;
        entry_depth   <= '0;
        entry_payload <= '0;
      end
      filled_count <= count_ext[3:0];
      games_total  <= games;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= TABLE_SLOTS)
    else $error("filled count above table size");

  a_found_holds: assert property (@(posedge clk) disable iff (rst)
    (found && cmd.walk_step) |=> found)
    else $error("insert position lost during walk");
`endif

endmodule

`default_nettype wire

[design/tnsit_ctrl.sv]
// controller: sequences capture, insert walk and result hand-off
`default_nettype none

module tnsit_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tnsit_pkg::MODE_W-1:0]  mode,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output tnsit_pkg::dp_cmd_t                 cmd,
  input  wire tnsit_pkg::dp_status_t         status
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (tnsit_pkg::mode_t'(mode) == tnsit_pkg::MODE_INSERT) begin
            state_next = ST_WALK;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.walk_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside finish");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && status.walk_last) |=> (state == ST_FINISH))
    else $error("walk did not end at last slot");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire

[design/top_n_sorted_insert_table.sv]
// top level of the sorted top-n table with games counter
//
//   channel  | handshake           | fields
//   ---------+---------------------+------------------------------------------------
//   input    | in_valid / in_stall | mode new_key new_depth new_payload read_index
//   output   | out_valid/out_stall | inserted insert_slot entry_key entry_depth
//            |                     | entry_payload filled_count games_total
//
// an insert accepts the item, walks the slot memory one slot at a time and then
// loads the result register
// read, tick and unused mode skip the walk and go straight to the result load
// reset clears the slot valid bits, fill count and games counter at once
// the next item is accepted while a result still waits; a stalled result
// holds the block only when the following result is ready
`default_nettype none

module top_n_sorted_insert_table #(
  parameter int TABLE_SLOTS  = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [tnsit_pkg::MODE_W-1:0]    mode,
  input  wire logic [tnsit_pkg::KEY_W-1:0]     new_key,
  input  wire logic [tnsit_pkg::DEPTH_W-1:0]   new_depth,
  input  wire logic [tnsit_pkg::IO_PAY_W-1:0]  new_payload,
  input  wire logic [tnsit_pkg::IDX_W-1:0]     read_index,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 inserted,
  output logic [tnsit_pkg::IDX_W-1:0]          insert_slot,
  output logic [tnsit_pkg::KEY_W-1:0]          entry_key,
  output logic [tnsit_pkg::DEPTH_W-1:0]        entry_depth,
  output logic [tnsit_pkg::IO_PAY_W-1:0]       entry_payload,
  output logic [tnsit_pkg::COUNT_W-1:0]        filled_count,
  output logic [tnsit_pkg::GAMES_W-1:0]        games_total
);

  tnsit_pkg::dp_cmd_t    cmd;
  tnsit_pkg::dp_status_t status;

  tnsit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  tnsit_dp #(
    .TABLE_SLOTS  (TABLE_SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (mode),
    .new_key       (new_key),
    .new_depth     (new_depth),
    .new_payload   (new_payload),
    .read_index    (read_index),
    .inserted      (inserted),
    .insert_slot   (insert_slot),
    .entry_key     (entry_key),
    .entry_depth   (entry_depth),
    .entry_payload (entry_payload),
    .filled_count  (filled_count),
    .games_total   (games_total)
  );

endmodule

`default_nettype wire
